// ===== design/per_channel_median_average_filter_assert.svh =====
// assertion macros shared by the filter checker
// expects clk_i and rst_ni in the scope of each use
`ifndef PER_CHANNEL_MEDIAN_AVERAGE_FILTER_ASSERT_SVH
`define PER_CHANNEL_MEDIAN_AVERAGE_FILTER_ASSERT_SVH

// same-cycle implication, off during reset
`define PCMAF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PCMAF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcmaf_pkg.sv =====
// shared types and constants of the per-channel median / average filter
// no dependencies
package pcmaf_pkg;

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam int CHANNELS_DEF = 6;
  localparam int WINDOW_DEF   = 5;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic signed [SAMPLE_W-1:0] RESET_TEMP = 12'sd288;
  localparam logic signed [SAMPLE_W-1:0] TEMP_MIN   = -12'sd880;
  localparam logic signed [SAMPLE_W-1:0] TEMP_MAX   = 12'sd2000;

  localparam logic [MASK_W-1:0] AVG_MASK_RST  = 6'd16;
  localparam logic [MASK_W-1:0] PRES_MASK_RST = 6'd63;
  localparam logic [MASK_W-1:0] CRIT_MASK_RST = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVERAGE  = 2'd0,
    CFG_PRESENT  = 2'd1,
    CFG_CRITICAL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LOST   = 2'd1,
    ST_CRIT   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    status_e                    status;
    logic                       use_avg;
  } req_t;

endpackage

// ===== design/per_channel_median_average_filter.sv =====
// per-channel median-of-window / moving-average temperature filter, top level
// depends on pcmaf_pkg, pcmaf_front, pcmaf_queue, pcmaf_back
// throughput one sample per cycle unless result back-pressure fills the queue; a sample goes
// through the queue entry, then the ring update stage, then median / divide into the result register
// reset: masks to defaults, every ring entry 18 degrees, sums to window times that,
// write positions and queue cleared; no clearing pass, input ready as soon as reset drops
module per_channel_median_average_filter
  import pcmaf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,  // 1..6
  parameter int WINDOW   = WINDOW_DEF     // 3..9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [MASK_W-1:0]     cfg_data_i,
  // sample requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // channel[2:0], sample[14:3], pad[15]
  // filtered results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_channel[2:0], filtered[14:3], pad[15]
  output logic [OUT_USER_W-1:0] m_axis_tuser    // status[1:0]
);

  // front to queue
  logic push, queue_full;
  req_t front_req;

  // queue to back
  logic q_valid, q_pop;
  req_t q_data;

  // front classifies each request: absent, lost / critical, or ok with its filter choice
  pcmaf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .queue_full_i (queue_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .req_o        (front_req)
  );

  // two-entry queue lets the input side keep going while a result is stalled
  pcmaf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_req),
    .full_o      (queue_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back owns all filter state; updates happen in order at pop time
  pcmaf_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== design/pcmaf_front.sv =====
// front end: configuration registers and request classification
// depends on pcmaf_pkg
module pcmaf_front
  import pcmaf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [MASK_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  queue_full_i,
  output logic                  in_ready_o,
  output logic                  push_o,
  output req_t                  req_o
);

  localparam int CH_NUM = 2 ** CH_W;

  logic [MASK_W-1:0] avg_mask_q, pres_mask_q, crit_mask_q;
  logic [CH_NUM-1:0] avg_ext, pres_ext, crit_ext;
  logic [CH_W-1:0]   ch;
  logic signed [SAMPLE_W-1:0] smp;
  logic              ch_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_mask_q  <= AVG_MASK_RST;
      pres_mask_q <= PRES_MASK_RST;
      crit_mask_q <= CRIT_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AVERAGE:  avg_mask_q  <= cfg_data_i;
        CFG_PRESENT:  pres_mask_q <= cfg_data_i;
        CFG_CRITICAL: crit_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // masks widened so every 3-bit channel code has a bit, missing ones read 0
  assign avg_ext  = CH_NUM'(avg_mask_q);
  assign pres_ext = CH_NUM'(pres_mask_q);
  assign crit_ext = CH_NUM'(crit_mask_q);

  assign ch          = in_data_i[CH_W-1:0];
  assign smp         = signed'(in_data_i[CH_W +: SAMPLE_W]);
  assign ch_in_range = 32'(ch) < CHANNELS;

  always_comb begin
    req_o.channel = ch;
    req_o.sample  = smp;
    req_o.use_avg = avg_ext[ch];
    if (!ch_in_range || !pres_ext[ch]) begin
      req_o.status = ST_ABSENT;
    end else if (smp < TEMP_MIN || smp > TEMP_MAX) begin
      req_o.status = crit_ext[ch] ? ST_CRIT : ST_LOST;
    end else begin
      req_o.status = ST_OK;
    end
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

// ===== design/pcmaf_queue.sv =====
// short request queue between front and back
// depends on pcmaf_pkg
module pcmaf_queue
  import pcmaf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== design/pcmaf_back.sv =====
// back end: per-channel ring state, median select, rounded average, result register
// depends on pcmaf_pkg
module pcmaf_back
  import pcmaf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int WINDOW   = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  req_t                  q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [OUT_USER_W-1:0] out_user_o
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * (1 << (SAMPLE_W - 1))) + 1;
  localparam int DIV_K = SUM_W + 4;
  localparam int PROD_W = SUM_W + DIV_K;
  localparam int HALF  = WINDOW / 2;
  localparam logic [DIV_K-1:0] RECIP = DIV_K'(((1 << DIV_K) + WINDOW - 1) / WINDOW);
  localparam int PAD_W = OUT_DATA_W - CH_W - SAMPLE_W;

  // channel state
  logic signed [SAMPLE_W-1:0] med_ring_q [CHANNELS][WINDOW];
  logic signed [SAMPLE_W-1:0] avg_ring_q [CHANNELS][WINDOW];
  logic [PW-1:0]              med_pos_q  [CHANNELS];
  logic [PW-1:0]              avg_pos_q  [CHANNELS];
  logic signed [SUM_W-1:0]    sum_q      [CHANNELS];

  // update stage
  logic                       adv, do_upd;
  logic [CW-1:0]              ci;
  logic [PW-1:0]              pos, next_pos;
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [SAMPLE_W-1:0] new_row [WINDOW];
  logic signed [SUM_W-1:0]    sum_new;

  logic                       b1_valid_q;
  logic [CH_W-1:0]            b1_ch_q;
  status_e                    b1_status_q;
  logic                       b1_avg_q;
  logic signed [SAMPLE_W-1:0] b1_row_q [WINDOW];
  logic signed [SUM_W-1:0]    b1_sum_q;

  // result stage
  logic [PW-1:0]              rank [WINDOW];
  logic signed [SAMPLE_W-1:0] med_val, avg_val, filt;
  logic                       neg;
  logic [SUM_W-1:0]           mag, quo;
  logic [PROD_W-1:0]          prod;

  logic                       out_valid_q;
  logic [CH_W-1:0]            out_ch_q;
  logic signed [SAMPLE_W-1:0] out_filt_q;
  status_e                    out_status_q;

  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = q_valid_i && adv;
  assign do_upd  = q_pop_o && (q_data_i.status == ST_OK);
  assign ci      = CW'(q_data_i.channel);

  always_comb begin
    pos      = q_data_i.use_avg ? avg_pos_q[ci] : med_pos_q[ci];
    next_pos = (pos == PW'(WINDOW - 1)) ? '0 : pos + 1'b1;
    old_val  = avg_ring_q[ci][pos];
    for (int k = 0; k < WINDOW; k++) begin
      if (PW'(k) == pos) begin
        new_row[k] = q_data_i.sample;
      end else begin
        new_row[k] = q_data_i.use_avg ? avg_ring_q[ci][k] : med_ring_q[ci][k];
      end
    end
    sum_new = sum_q[ci] - SUM_W'(old_val) + SUM_W'(q_data_i.sample);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < WINDOW; k++) begin
          med_ring_q[c][k] <= RESET_TEMP;
          avg_ring_q[c][k] <= RESET_TEMP;
        end
        med_pos_q[c] <= '0;
        avg_pos_q[c] <= '0;
        sum_q[c]     <= SUM_W'(RESET_TEMP) * SUM_W'(WINDOW);
      end
    end else if (do_upd) begin
      if (q_data_i.use_avg) begin
        avg_ring_q[ci][pos] <= q_data_i.sample;
        avg_pos_q[ci]       <= next_pos;
        sum_q[ci]           <= sum_new;
      end else begin
        med_ring_q[ci][pos] <= q_data_i.sample;
        med_pos_q[ci]       <= next_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_ch_q     <= q_data_i.channel;
      b1_status_q <= q_data_i.status;
      b1_avg_q    <= q_data_i.use_avg;
      b1_row_q    <= new_row;
      b1_sum_q    <= sum_new;
    end
  end

  // median: element whose stable rank is the middle one
  always_comb begin
    med_val = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if (b1_row_q[j] < b1_row_q[i] || (b1_row_q[j] == b1_row_q[i] && j < i)) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
      if (rank[i] == PW'(HALF)) med_val = med_val | b1_row_q[i];
    end
  end

  // average: round half away from zero by reciprocal multiply on the magnitude
  always_comb begin
    neg     = b1_sum_q[SUM_W-1];
    mag     = (neg ? SUM_W'(-b1_sum_q) : SUM_W'(b1_sum_q)) + SUM_W'(HALF);
    prod    = PROD_W'(mag) * PROD_W'(RECIP);
    quo     = prod[PROD_W-1:DIV_K];
    avg_val = neg ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
    if (b1_status_q != ST_OK) begin
      filt = '0;
    end else begin
      filt = b1_avg_q ? avg_val : med_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch_q     <= b1_ch_q;
      out_filt_q   <= filt;
      out_status_q <= b1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {PAD_W'(0), out_filt_q, out_ch_q};
  assign out_user_o  = out_status_q;

endmodule

// ===== design/pcmaf_checker.sv =====
// port-level checks of the filter output and the bind that attaches them
// depends on pcmaf_pkg and per_channel_median_average_filter_assert.svh
`include "per_channel_median_average_filter_assert.svh"

module pcmaf_checker
  import pcmaf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic signed [SAMPLE_W-1:0] filt;
  logic [CH_W-1:0]            ch;

  assign filt = signed'(m_axis_tdata[CH_W +: SAMPLE_W]);
  assign ch   = m_axis_tdata[CH_W-1:0];

  `PCMAF_ASSERT_NOW(a_ok_in_range, m_axis_tvalid && m_axis_tuser == ST_OK, filt >= TEMP_MIN && filt <= TEMP_MAX, "ok result outside valid temperature range")
  `PCMAF_ASSERT_NOW(a_bad_is_zero, m_axis_tvalid && m_axis_tuser != ST_OK, filt == '0, "non-ok result carries a nonzero value")
  `PCMAF_ASSERT_NOW(a_chan_known, m_axis_tvalid && m_axis_tuser != ST_ABSENT, 32'(ch) < CHANNELS, "result for a nonexistent channel not marked absent")
  `PCMAF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind per_channel_median_average_filter pcmaf_checker #(
  .CHANNELS (CHANNELS)
) u_pcmaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_per_channel_median_average_filter.sv =====
// self-checking bench for the per-channel median / moving-average filter
// depends on pcmaf_pkg and per_channel_median_average_filter; a checker class
// predicts each result, plain tasks drive the sample and mask ports, an always block the result ready
module tb_per_channel_median_average_filter;
  import pcmaf_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int WIN         = WINDOW_DEF;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int IDLE_PCT    = 34;

  // register index past the end of the list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one filter result as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] value;
    status_e                    status;
  } reading_t;

  // mirror of the filter state plus the queue of readings still owed by the block
  class reading_checker;
    logic [MASK_W-1:0] avg_mask;
    logic [MASK_W-1:0] present_mask;
    logic [MASK_W-1:0] critical_mask;
    int                median_hist [NCH][WIN];
    int                median_pos  [NCH];
    int                avg_hist    [NCH][WIN];
    int                avg_pos     [NCH];
    int                avg_total   [NCH];
    reading_t          expected_q[$];
    int                mismatches;
    int                checked;
    int                status_seen [4];

    function new();
      avg_mask      = AVG_MASK_RST;
      present_mask  = PRES_MASK_RST;
      critical_mask = CRIT_MASK_RST;
      for (int c = 0; c < NCH; c++) begin
        for (int i = 0; i < WIN; i++) begin
          median_hist[c][i] = int'(RESET_TEMP);
          avg_hist[c][i]    = int'(RESET_TEMP);
        end
        median_pos[c] = 0;
        avg_pos[c]    = 0;
        avg_total[c]  = int'(RESET_TEMP) * WIN;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
      case (idx)
        CFG_AVERAGE:  avg_mask = val;
        CFG_PRESENT:  present_mask = val;
        CFG_CRITICAL: critical_mask = val;
        default: ;
      endcase
    endfunction

    // middle entry of the channel's median window, sorted on a copy
    function int window_median(int ch);
      int w [WIN];
      int t;
      int j;
      for (int i = 0; i < WIN; i++) w[i] = median_hist[ch][i];
      for (int i = 1; i < WIN; i++) begin
        t = w[i];
        j = i - 1;
        while (j >= 0 && w[j] > t) begin
          w[j + 1] = w[j];
          j--;
        end
        w[j + 1] = t;
      end
      return w[WIN / 2];
    endfunction

    // window sum over window size, rounded to nearest, ties away from zero
    function int window_mean(int total);
      if (total >= 0) return (total + WIN / 2) / WIN;
      return -((-total + WIN / 2) / WIN);
    endfunction

    function reading_t filter_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] s);
      reading_t r;
      int       p;
      r.channel = ch;
      r.value   = '0;
      r.status  = ST_OK;
      if (ch >= NCH) begin
        r.status = ST_ABSENT;
      end else if (!present_mask[ch]) begin
        r.status = ST_ABSENT;
      end else if (s < TEMP_MIN || s > TEMP_MAX) begin
        r.status = critical_mask[ch] ? ST_CRIT : ST_LOST;
      end else if (avg_mask[ch]) begin
        p = avg_pos[ch];
        avg_total[ch] -= avg_hist[ch][p];
        avg_hist[ch][p] = int'(s);
        avg_total[ch] += int'(s);
        avg_pos[ch] = (p + 1) % WIN;
        r.value = SAMPLE_W'(window_mean(avg_total[ch]));
      end else begin
        p = median_pos[ch];
        median_hist[ch][p] = int'(s);
        median_pos[ch] = (p + 1) % WIN;
        r.value = SAMPLE_W'(window_median(ch));
      end
      return r;
    endfunction

    function void note_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] s);
      expected_q.push_back(filter_sample(ch, s));
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: channel %0d filtered %0d status %s",
                   got.channel, $signed(got.value), got.status.name());
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[int'(got.status)]++;
      if (got.channel !== want.channel || got.value !== want.value ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: channel %0d/%0d filtered %0d/%0d status %s/%s (exp/got)",
                   want.channel, got.channel, $signed(want.value), $signed(got.value),
                   want.status.name(), got.status.name());
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [MASK_W-1:0]     cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // channel[2:0], sample[14:3], pad[15]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // out_channel[2:0], filtered[14:3], pad[15]
  logic [OUT_USER_W-1:0] m_axis_tuser;   // status[1:0]

  reading_checker chk;
  bit             steady;        // both sides run without idling while set
  int             quiet_cycles;  // cycles since the last handshake on either side
  int             sent;
  int             settings;

  per_channel_median_average_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 unit period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side back-pressure, random unless in the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  // both handshakes are sampled here, with pre-edge values; a request is noted
  // before any result of the same edge is checked
  always @(posedge clk_i) begin : monitor
    reading_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        chk.note_sample(s_axis_tdata[CH_W-1:0], s_axis_tdata[CH_W +: SAMPLE_W]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel = m_axis_tdata[CH_W-1:0];
        got.value   = m_axis_tdata[CH_W +: SAMPLE_W];
        got.status  = status_e'(m_axis_tuser);
        chk.check_result(got);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: the block has stopped moving
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("per_channel_median_average_filter regression: fail");
    $finish;
  end

  // mostly in-range channels, a few beyond the last one
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99) < 92) return CH_W'($urandom_range(NCH - 1));
    return CH_W'($urandom_range(7, NCH));
  endfunction

  // mostly valid temperatures, some hugging the limits, the rest any raw code
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return SAMPLE_W'(int'($urandom_range(2880)) - 880);
    if (roll < 80)
      return SAMPLE_W'(int'($urandom_range(1) ? TEMP_MAX : TEMP_MIN) +
                       int'($urandom_range(4)) - 2);
    return SAMPLE_W'($urandom_range(4095));
  endfunction

  // one sample request; valid stays high afterwards so back-to-back requests
  // never drop it, idle gaps are inserted before raising it
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - CH_W - SAMPLE_W){1'b0}}, s, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_channel(), pick_sample());
  endtask

  // drop valid and wait until every owed result is out, then a little margin
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chk.expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // back-to-back writes of all three masks, optionally the unused index too
  task automatic program_masks(input logic [MASK_W-1:0] avg, input logic [MASK_W-1:0] pres,
                               input logic [MASK_W-1:0] crit, input bit with_spare);
    logic [MASK_W-1:0] junk;
    junk = MASK_W'($urandom_range(63));
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_AVERAGE;
    cfg_data_i <= avg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PRESENT;
    cfg_data_i <= pres;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CRITICAL;
    cfg_data_i <= crit;
    @(posedge clk_i);
    if (with_spare) begin
      cfg_idx_i  <= CFG_SPARE;
      cfg_data_i <= junk;
      @(posedge clk_i);
      chk.set_register(CFG_SPARE, junk);
    end
    cfg_we_i <= 1'b0;
    chk.set_register(CFG_AVERAGE, avg);
    chk.set_register(CFG_PRESENT, pres);
    chk.set_register(CFG_CRITICAL, crit);
    settings++;
  endtask

  initial begin : stimulus
    int leftover;
    chk           = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_AVERAGE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    sent          = 0;
    settings      = 1;  // reset defaults count as the first setting

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset masks: channel 4 averages and is critical
    send_sample(3'd0, -12'sd880);    // lowest valid temperature
    send_sample(3'd0, 12'sd2000);    // highest valid temperature
    send_sample(3'd0, -12'sd881);    // just below range, lost
    send_sample(3'd0, 12'sd2001);    // just above range, lost
    send_sample(3'd0, -12'sd2048);   // most negative code
    send_sample(3'd0, 12'sd2047);    // most positive code
    send_sample(3'd1, 12'sd0);
    send_sample(3'd1, -12'sd1);      // all ones in the sample field
    send_sample(3'd4, 12'sd2000);    // moving average
    send_sample(3'd4, -12'sd880);
    send_sample(3'd4, -12'sd881);    // critical loss
    send_sample(3'd4, 12'sd2047);    // critical loss
    send_sample(3'd4, -12'sd1);
    send_sample(3'd4, 12'sd2001);
    send_sample(3'd5, 12'sd288);
    send_sample(3'd6, 12'sd100);     // channel past the last one
    send_sample(3'd7, -12'sd2048);   // all ones in the channel field
    send_sample(3'd3, 12'sd1999);
    send_sample(3'd2, -12'sd879);
    send_sample(3'd7, 12'sd2047);
    random_burst(100);
    settle();

    // every channel averaging, no critical sensors, no idling on either side
    program_masks(6'h3f, 6'h3f, 6'h00, 1'b0);
    steady = 1'b1;
    random_burst(150);
    settle();
    steady = 1'b0;

    // every channel on the median filter, every sensor critical
    program_masks(6'h00, 6'h3f, 6'h3f, 1'b0);
    random_burst(130);
    settle();

    // no sensor present at all, write to the unused index as well
    program_masks(MASK_W'($urandom_range(63)), 6'h00, MASK_W'($urandom_range(63)), 1'b1);
    random_burst(40);
    settle();

    // mixed masks
    repeat (3) begin
      program_masks(MASK_W'($urandom_range(63)), MASK_W'($urandom_range(63)),
                    MASK_W'($urandom_range(63)), 1'b1);
      random_burst(110);
      settle();
    end

    repeat (8) @(posedge clk_i);
    leftover = chk.expected_q.size();
    $display("%0d sample requests under %0d mask settings, %0d results checked, %0d left over",
             sent, settings, chk.checked, leftover);
    $display("status seen: ok %0d, lost %0d, critical lost %0d, absent %0d; %0d mismatches",
             chk.status_seen[0], chk.status_seen[1], chk.status_seen[2], chk.status_seen[3],
             chk.mismatches);
    if (chk.mismatches == 0 && leftover == 0) begin
      $display("per_channel_median_average_filter regression: pass");
    end else begin
      $display("per_channel_median_average_filter regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pcmaf_pkg.sv
design/pcmaf_front.sv
design/pcmaf_queue.sv
design/pcmaf_back.sv
design/per_channel_median_average_filter.sv
design/pcmaf_checker.sv
tb/sv/tb_per_channel_median_average_filter.sv
